FILE: rtl/greenhouse_climate_decider_assert.svh
// Assertion macros used by the greenhouse climate decider checker.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef GREENHOUSE_CLIMATE_DECIDER_ASSERT_SVH
`define GREENHOUSE_CLIMATE_DECIDER_ASSERT_SVH

// Same-cycle implication, quiet while reset is held.
`define GCD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define GCD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/gcd_pkg.sv
// Types and fixed constants of the greenhouse climate decider.
// No dependencies; the calibration, top-level and checker modules import this package.
package gcd_pkg;

    // Field widths
    localparam int TEMP_IN_W  = 12;
    localparam int SOIL_W     = 12;
    localparam int TEMP_W     = 15;
    localparam int LUX_W      = 16;
    localparam int MOIST_W    = 7;
    localparam int PULSE_W    = 16;
    localparam int SHADE_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Calibration constants
    localparam int TEMP_GAIN_Q16  = 690749;
    localparam int TEMP_OFFS_Q16  = 1488978;
    localparam int TEMP_MIN       = -4300;
    localparam int TEMP_MAX       = 13200;
    localparam int TEMP_BIAS      = 4300;
    localparam int LUX_GAIN_Q16   = 65438;
    localparam int LUX_ROUND      = 32768;
    localparam int SOIL_DRY       = 3241;
    // floor(2*d/35) == floor(d*100/1750); reciprocal of 35 in Q20
    localparam int SOIL_RCP       = 29960;
    localparam int SOIL_RCP_SHIFT = 20;
    localparam int MOIST_MAX      = 100;
    localparam int MOIST_LOW      = 10;
    localparam int MOIST_HIGH     = 50;

    // Register reset values
    localparam int TEMP_HIGH_RST = 2700;
    localparam int TEMP_LOW_RST  = 2300;
    localparam int LUX_LOW_RST   = 7290;
    localparam int LUX_HIGH_RST  = 8910;
    localparam int IRRIG_MS_RST  = 18610;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_HIGH = 3'd0,
        REG_TEMP_LOW  = 3'd1,
        REG_LUX_LOW   = 3'd2,
        REG_LUX_HIGH  = 3'd3,
        REG_IRRIG_MS  = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        SHADE_HOLD  = 2'd0,
        SHADE_OPEN  = 2'd1,
        SHADE_CLOSE = 2'd2
    } t_shade_move;

    typedef struct packed {
        logic signed [TEMP_IN_W-1:0] temp_tenths;
        logic [LUX_W-1:0]            lux_reading;
        logic [SOIL_W-1:0]           soil_adc;
    } t_sample;

    typedef struct packed {
        logic signed [TEMP_W-1:0] avg_temp_centi;
        logic [LUX_W-1:0]         avg_lux;
        logic [MOIST_W-1:0]       avg_moist_pct;
        logic                     cooling_on;
        logic                     irrigate;
        logic [PULSE_W-1:0]       pulse_ms;
        t_shade_move              shade_move;
        logic [SHADE_W-1:0]       shade_position;
        logic                     grow_light_on;
    } t_result;

    // One calibrated sample set; temperature carries a +TEMP_BIAS offset
    typedef struct packed {
        logic [TEMP_W-1:0]  temp_biased;
        logic [LUX_W-1:0]   lux;
        logic [MOIST_W-1:0] moist;
    } t_cal;

endpackage

FILE: rtl/gcd_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
// Payload type is set per instance; no package dependency.
interface gcd_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/gcd_calib.sv
// Per-sample calibration of temperature, light and soil moisture.
// Depends on gcd_pkg.
module gcd_calib #(
    parameter int SOIL_ADC_BITS = 12
) (
    input  gcd_pkg::t_sample i_sample,
    output gcd_pkg::t_cal    o_cal
);
    import gcd_pkg::*;

    localparam logic [SOIL_W-1:0] SOIL_MASK = SOIL_W'((1 << SOIL_ADC_BITS) - 1);

    logic signed [33:0] temp_prod;
    logic signed [17:0] temp_c;
    logic signed [17:0] temp_sat;
    logic [32:0]        lux_prod;
    logic [SOIL_W-1:0]  soil_m;
    logic [SOIL_W-1:0]  soil_d;
    logic [SOIL_W:0]    soil_y;
    logic [27:0]        soil_prod;
    logic [7:0]         soil_q;

    always_comb begin
        // Q16 gain and offset, floor by arithmetic shift, then saturate
        temp_prod = 34'(i_sample.temp_tenths) * 34'(TEMP_GAIN_Q16) - 34'(TEMP_OFFS_Q16);
        temp_c    = 18'(temp_prod >>> 16);
        if (temp_c < 18'(TEMP_MIN)) begin
            temp_sat = 18'(TEMP_MIN);
        end else if (temp_c > 18'(TEMP_MAX)) begin
            temp_sat = 18'(TEMP_MAX);
        end else begin
            temp_sat = temp_c;
        end
        o_cal.temp_biased = TEMP_W'(temp_sat + 18'(TEMP_BIAS));

        // Round to nearest
        lux_prod  = 33'(i_sample.lux_reading) * 33'(LUX_GAIN_Q16) + 33'(LUX_ROUND);
        o_cal.lux = lux_prod[31:16];

        // Linear map, dry end reads zero, wet end clamps at full scale
        soil_m    = i_sample.soil_adc & SOIL_MASK;
        soil_d    = '0;
        soil_y    = '0;
        soil_prod = '0;
        soil_q    = '0;
        if (soil_m >= SOIL_W'(SOIL_DRY)) begin
            o_cal.moist = '0;
        end else begin
            soil_d    = SOIL_W'(SOIL_DRY) - soil_m;
            soil_y    = {soil_d, 1'b0};
            soil_prod = 28'(soil_y) * 28'(SOIL_RCP);
            soil_q    = 8'(soil_prod >> SOIL_RCP_SHIFT);
            o_cal.moist = (soil_q > 8'(MOIST_MAX)) ? MOIST_W'(MOIST_MAX) : soil_q[MOIST_W-1:0];
        end
    end

endmodule

FILE: rtl/greenhouse_climate_decider.sv
// Greenhouse climate decider: calibrates sensor sample sets and issues one decision
// per SAMPLES_PER_DECISION sets. Depends on gcd_pkg, gcd_stream_if and gcd_calib.
//
// Each beat on i_sample is one set of raw readings (temperature in 0.1 degC, lux,
// soil converter code). The block calibrates every set, adds it to running sums and,
// on the last set of a group, emits one beat on o_result with the three averages and
// the cooling, irrigation, shade and grow light decisions; the other beats produce
// nothing. The datapath is four register stages (input capture, calibration,
// accumulation, decision/output), so a beat is taken every cycle while the output
// does not stall, and the result beat is offered once the beat closing the group
// has passed the calibration, accumulation and output registers. Apart from reset,
// only the output register slows intake: while it holds a result that o_result has not
// taken, every stage holds and i_sample.ready stays low. Cooling follows hysteresis
// (on above temp_high, off below temp_low, hold in between, with the "above" test
// winning if the limits cross). Irrigation is requested while the exact mean
// moisture lies strictly between 10 and 50 percent. The shade moves one step per
// decision between open (0) and MAX_SHADE_STEPS; in low light at level 0 the grow
// light turns on, and closing the shade turns it off. Registers are written through
// i_cfg_we/i_cfg_idx/i_cfg_data; write them only while no group is in flight.
module greenhouse_climate_decider #(
    parameter int SAMPLES_PER_DECISION = 3,
    parameter int MAX_SHADE_STEPS      = 4,
    parameter int SOIL_ADC_BITS        = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    gcd_stream_if.sink                       i_sample,
    gcd_stream_if.source                     o_result,
    input  logic                             i_cfg_we,
    input  logic [gcd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gcd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import gcd_pkg::*;

    localparam int N       = SAMPLES_PER_DECISION;
    localparam int NB      = $clog2(N);
    localparam int CNT_W   = (N > 1) ? NB : 1;
    localparam int TSUM_W  = TEMP_W + NB;
    localparam int LSUM_W  = LUX_W + NB;
    localparam int MSUM_W  = MOIST_W + NB;
    localparam int THR_T_W = TEMP_W + 2 + NB;

    // Divide-by-N through a reciprocal: exact while sum * error < 2**K
    localparam int K_T  = TSUM_W + 3;
    localparam int K_L  = LSUM_W + 3;
    localparam int K_M  = MSUM_W + 3;
    localparam logic [K_T:0] RCP_T = (K_T+1)'(((2 ** K_T) + N - 1) / N);
    localparam logic [K_L:0] RCP_L = (K_L+1)'(((2 ** K_L) + N - 1) / N);
    localparam logic [K_M:0] RCP_M = (K_M+1)'(((2 ** K_M) + N - 1) / N);
    localparam int PT_W = TSUM_W + K_T + 1;
    localparam int PL_W = LSUM_W + K_L + 1;
    localparam int PM_W = MSUM_W + K_M + 1;

    // Thresholds are kept pre-scaled by N (temperature also biased)
    localparam logic signed [THR_T_W-1:0] THR_T_HI_RST = THR_T_W'((TEMP_HIGH_RST + TEMP_BIAS) * N);
    localparam logic signed [THR_T_W-1:0] THR_T_LO_RST = THR_T_W'((TEMP_LOW_RST + TEMP_BIAS) * N);
    localparam logic [LSUM_W-1:0] THR_L_LO_RST = LSUM_W'(LUX_LOW_RST * N);
    localparam logic [LSUM_W-1:0] THR_L_HI_RST = LSUM_W'(LUX_HIGH_RST * N);
    localparam logic [MSUM_W-1:0] MOIST_LO_N   = MSUM_W'(MOIST_LOW * N);
    localparam logic [MSUM_W-1:0] MOIST_HI_N   = MSUM_W'(MOIST_HIGH * N);

    // Pipeline control and payload
    logic               en;
    logic               r_s0_vld;
    t_sample            r_s0_smp;
    t_cal               cal;
    logic               r_s1_vld;
    t_cal               r_s1_cal;
    logic [CNT_W-1:0]   r_cnt;
    logic [TSUM_W-1:0]  r_tsum;
    logic [LSUM_W-1:0]  r_lsum;
    logic [MSUM_W-1:0]  r_msum;
    logic [TSUM_W-1:0]  n_tsum;
    logic [LSUM_W-1:0]  n_lsum;
    logic [MSUM_W-1:0]  n_msum;
    logic               last;
    logic               r_s2_vld;
    logic [TSUM_W-1:0]  r_s2_tsum;
    logic [LSUM_W-1:0]  r_s2_lsum;
    logic [MSUM_W-1:0]  r_s2_msum;
    logic               r_out_vld;
    t_result            r_out;
    t_result            n_out;

    // Decision state
    logic               r_cool;
    logic [SHADE_W-1:0] r_shade;
    logic               r_grow;
    logic               n_cool;
    logic [SHADE_W-1:0] n_shade;
    logic               n_grow;
    t_shade_move        n_move;

    // Configuration
    logic signed [THR_T_W-1:0] r_thr_t_hi;
    logic signed [THR_T_W-1:0] r_thr_t_lo;
    logic [LSUM_W-1:0]         r_thr_l_lo;
    logic [LSUM_W-1:0]         r_thr_l_hi;
    logic [PULSE_W-1:0]        r_irrig_ms;
    logic signed [THR_T_W-1:0] n_thr_t;
    logic [LSUM_W-1:0]         n_thr_l;

    // Averaging and compare datapath
    logic [PT_W-1:0]           t_prod;
    logic [PL_W-1:0]           l_prod;
    logic [PM_W-1:0]           m_prod;
    logic signed [TEMP_W:0]    avg_t_wide;
    logic signed [THR_T_W-1:0] tsum_s;
    logic                      hot;
    logic                      cold;
    logic                      lux_dark;
    logic                      lux_bright;
    logic                      irr;

    // Advance everything whenever the output register is free or being drained
    assign en             = !r_out_vld || o_result.ready;
    assign i_sample.ready = en && i_rst_n;
    assign o_result.valid = r_out_vld;
    assign o_result.data  = r_out;

    gcd_calib #(
        .SOIL_ADC_BITS (SOIL_ADC_BITS)
    ) u_calib (
        .i_sample (r_s0_smp),
        .o_cal    (cal)
    );

    // Accumulation stage
    always_comb begin
        n_tsum = r_tsum + TSUM_W'(r_s1_cal.temp_biased);
        n_lsum = r_lsum + LSUM_W'(r_s1_cal.lux);
        n_msum = r_msum + MSUM_W'(r_s1_cal.moist);
        last   = (r_cnt == CNT_W'(N - 1));
    end

    // Decision stage: averages by reciprocal, decisions on the exact sums
    always_comb begin
        t_prod     = PT_W'(r_s2_tsum) * PT_W'(RCP_T);
        l_prod     = PL_W'(r_s2_lsum) * PL_W'(RCP_L);
        m_prod     = PM_W'(r_s2_msum) * PM_W'(RCP_M);
        avg_t_wide = $signed({1'b0, TEMP_W'(t_prod >> K_T)}) - (TEMP_W+1)'(TEMP_BIAS);

        tsum_s     = $signed(THR_T_W'(r_s2_tsum));
        hot        = tsum_s > r_thr_t_hi;
        cold       = tsum_s < r_thr_t_lo;
        n_cool     = hot ? 1'b1 : (cold ? 1'b0 : r_cool);

        irr        = (r_s2_msum > MOIST_LO_N) && (r_s2_msum < MOIST_HI_N);

        lux_dark   = r_s2_lsum < r_thr_l_lo;
        lux_bright = r_s2_lsum > r_thr_l_hi;
        n_shade    = r_shade;
        n_grow     = r_grow;
        n_move     = SHADE_HOLD;
        if (lux_dark) begin
            if (r_shade != '0) begin
                n_shade = r_shade - 1'b1;
                n_move  = SHADE_OPEN;
            end else begin
                n_grow = 1'b1;
            end
        end else if (lux_bright && (r_shade < SHADE_W'(MAX_SHADE_STEPS))) begin
            n_grow  = 1'b0;
            n_shade = r_shade + 1'b1;
            n_move  = SHADE_CLOSE;
        end

        n_out.avg_temp_centi = TEMP_W'(avg_t_wide);
        n_out.avg_lux        = LUX_W'(l_prod >> K_L);
        n_out.avg_moist_pct  = MOIST_W'(m_prod >> K_M);
        n_out.cooling_on     = n_cool;
        n_out.irrigate       = irr;
        n_out.pulse_ms       = irr ? r_irrig_ms : '0;
        n_out.shade_move     = n_move;
        n_out.shade_position = n_shade;
        n_out.grow_light_on  = n_grow;
    end

    // Control state: stage valids, sample counter, running sums, decision state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_cnt     <= '0;
            r_tsum    <= '0;
            r_lsum    <= '0;
            r_msum    <= '0;
            r_cool    <= 1'b0;
            r_shade   <= '0;
            r_grow    <= 1'b0;
        end else if (en) begin
            r_s0_vld  <= i_sample.valid;
            r_s1_vld  <= r_s0_vld;
            r_s2_vld  <= r_s1_vld && last;
            r_out_vld <= r_s2_vld;
            if (r_s1_vld) begin
                if (last) begin
                    // Close the group: hand totals on, restart the sums
                    r_cnt  <= '0;
                    r_tsum <= '0;
                    r_lsum <= '0;
                    r_msum <= '0;
                end else begin
                    r_cnt  <= r_cnt + 1'b1;
                    r_tsum <= n_tsum;
                    r_lsum <= n_lsum;
                    r_msum <= n_msum;
                end
            end
            if (r_s2_vld) begin
                r_cool  <= n_cool;
                r_shade <= n_shade;
                r_grow  <= n_grow;
            end
        end
    end

    // Payload registers: load on advance, hold otherwise
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_smp <= i_sample.data;
            r_s1_cal <= cal;
            if (r_s1_vld && last) begin
                r_s2_tsum <= n_tsum;
                r_s2_lsum <= n_lsum;
                r_s2_msum <= n_msum;
            end
            if (r_s2_vld) begin
                r_out <= n_out;
            end
        end
    end

    // Scale incoming thresholds by N once, at write time
    always_comb begin
        n_thr_t = (THR_T_W'($signed(i_cfg_data[TEMP_W-1:0])) + THR_T_W'(TEMP_BIAS))
                  * THR_T_W'(N);
        n_thr_l = LSUM_W'(i_cfg_data) * LSUM_W'(N);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_t_hi <= THR_T_HI_RST;
            r_thr_t_lo <= THR_T_LO_RST;
            r_thr_l_lo <= THR_L_LO_RST;
            r_thr_l_hi <= THR_L_HI_RST;
            r_irrig_ms <= PULSE_W'(IRRIG_MS_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TEMP_HIGH: r_thr_t_hi <= n_thr_t;
                REG_TEMP_LOW:  r_thr_t_lo <= n_thr_t;
                REG_LUX_LOW:   r_thr_l_lo <= n_thr_l;
                REG_LUX_HIGH:  r_thr_l_hi <= n_thr_l;
                REG_IRRIG_MS:  r_irrig_ms <= i_cfg_data;
                default: begin
                    // Drop writes to unmapped indexes
                end
            endcase
        end
    end

endmodule

FILE: rtl/gcd_checker.sv
// Port-level checks for the greenhouse climate decider, bound to the top level.
// Depends on gcd_pkg and greenhouse_climate_decider_assert.svh.
`include "greenhouse_climate_decider_assert.svh"

module gcd_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input gcd_pkg::t_result i_out
);
    import gcd_pkg::*;

    // A stalled result beat stays offered
    `GCD_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result beat dropped while stalled")

    // An empty output register never blocks intake
    `GCD_ASSERT_IMP(a_ready_free, !i_out_valid, i_in_ready, "input stalled with empty output")

    // No pulse length without an irrigation request
    `GCD_ASSERT_IMP(a_pulse_zero, i_out_valid && !i_out.irrigate, i_out.pulse_ms == '0, "pulse length without irrigate")

    // Irrigation only while the mean moisture lies inside the band
    `GCD_ASSERT_IMP(a_irr_band, i_out_valid && i_out.irrigate, (i_out.avg_moist_pct >= MOIST_W'(MOIST_LOW)) && (i_out.avg_moist_pct < MOIST_W'(MOIST_HIGH)), "irrigate outside band")

    // Closing the shade leaves it off the open stop and the grow light dark
    `GCD_ASSERT_IMP(a_close_dark, i_out_valid && (i_out.shade_move == SHADE_CLOSE), !i_out.grow_light_on && (i_out.shade_position != '0), "bad state after shade close")

endmodule

bind greenhouse_climate_decider gcd_checker u_gcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out       (o_result.data)
);
